### rtl/core/msd_pkg.sv
// Shared constants, types and helpers for the MOV-store source decoder.
package msd_pkg;

    // Longest instruction the parser accepts, in bytes.
    localparam int MAX_LEN = 15;

    localparam int SKIP_W = 3;
    localparam int CNT_W  = 4;
    localparam int SUM_W  = 5;

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_PREFIX = 7'b0000010,
        PH_OPCODE = 7'b0000100,
        PH_MODRM  = 7'b0001000,
        PH_SIB    = 7'b0010000,
        PH_DISP   = 7'b0100000,
        PH_IMM    = 7'b1000000
    } phase_t;

    // Result status codes.
    localparam logic [1:0] ST_REG  = 2'd0;
    localparam logic [1:0] ST_IMM  = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // Opcodes of the supported subset.
    localparam logic [7:0] OP_MOV_RM8   = 8'h88;
    localparam logic [7:0] OP_MOV_RM32  = 8'h89;
    localparam logic [7:0] OP_MOV_IMM8  = 8'hC6;
    localparam logic [7:0] OP_MOV_IMM32 = 8'hC7;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_RIP     = 3'd5;

    function automatic logic legacy_prefix(input logic [7:0] b);
        logic hit;
        begin
            case (b)
                8'hF0, 8'hF2, 8'hF3,
                8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65,
                8'h66, 8'h67: hit = 1'b1;
                default:      hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

### rtl/core/mov_store_source_decoder.sv
// Byte-serial x86-64 MOV-store decoder: source register or immediate and length.
//
//  Channel | Direction | tdata (low bit up)                    | tuser
//  s_*     | in        | insn_byte[7:0]                        | first_byte
//  m_*     | out       | source_reg, imm_value, insn_length    | status[1:0]
//
// One instruction byte is taken per clock while s_tready is high; the parser state and the result
// register are updated in the same cycle, so bytes stream back to back.
// A result word is held in the output register until taken; s_tready drops
// only while that register is full and m_tready is low.
// rst_n clears the parser to idle and empties the output register.
module mov_store_source_decoder
    import msd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // insn_byte[7:0]
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // source_reg[3:0], imm_value[35:4], insn_length[39:36]
    output logic [1:0]  m_tuser    // status[1:0]
);

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    byte_count_reg, byte_count_next;
    logic [2:0]          prefix_count_reg, prefix_count_next;
    logic                rex_r_reg, rex_r_next;
    logic [7:0]          opcode_reg, opcode_next;
    logic [7:0]          modrm_byte_reg, modrm_byte_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [SKIP_W-1:0]   imm_left_reg, imm_left_next;
    logic [31:0]         imm_acc_reg, imm_acc_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [3:0]          out_src_reg, out_src_next;
    logic [31:0]         out_imm_reg, out_imm_next;
    logic [3:0]          out_len_reg, out_len_next;

    logic                accept;
    logic                emit;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_len_reg, out_imm_reg, out_src_reg};

    always_comb
    begin
        logic [7:0]       b;
        logic             fail;
        logic             done;
        logic             adv;
        logic [1:0]       mod_f;
        logic [2:0]       rm_f;
        logic [1:0]       k;
        logic [SUM_W-1:0] need;
        logic [SUM_W-1:0] total;

        b     = s_tdata;
        fail  = 1'b0;
        done  = 1'b0;
        adv   = 1'b0;
        mod_f = b[7:6];
        rm_f  = b[2:0];
        k     = 2'd0;
        need  = '0;
        total = '0;

        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        prefix_count_next = prefix_count_reg;
        rex_r_next        = rex_r_reg;
        opcode_next       = opcode_reg;
        modrm_byte_next   = modrm_byte_reg;
        skip_next         = skip_reg;
        imm_left_next     = imm_left_reg;
        imm_acc_next      = imm_acc_reg;

        if (s_tuser)
        begin
            phase_next        = PH_PREFIX;
            byte_count_next   = '0;
            prefix_count_next = '0;
            rex_r_next        = 1'b0;
            opcode_next       = '0;
            modrm_byte_next   = '0;
            skip_next         = '0;
            imm_left_next     = '0;
            imm_acc_next      = '0;
        end

        if (phase_next != PH_IDLE)
        begin
            if (byte_count_next >= CNT_W'(MAX_LEN))
            begin
                fail = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_next + CNT_W'(1);
                case (phase_next)
                    PH_PREFIX, PH_OPCODE:
                    begin
                        if (phase_next == PH_PREFIX && prefix_count_next < 3'd4
                            && legacy_prefix(b))
                        begin
                            prefix_count_next = prefix_count_next + 3'd1;
                        end
                        else if (phase_next == PH_PREFIX && b[7:4] == 4'h4)
                        begin
                            rex_r_next = b[2];
                            phase_next = PH_OPCODE;
                        end
                        else
                        begin
                            opcode_next = b;
                            phase_next  = PH_MODRM;
                            if (b == OP_MOV_RM8 || b == OP_MOV_RM32)
                                imm_left_next = 3'd0;
                            else if (b == OP_MOV_IMM32)
                                imm_left_next = 3'd4;
                            else if (b == OP_MOV_IMM8)
                                imm_left_next = 3'd1;
                            else
                                fail = 1'b1;
                        end
                    end
                    PH_MODRM:
                    begin
                        modrm_byte_next = b;
                        if (mod_f == MOD_DISP8)
                            skip_next = 3'd1;
                        else if (mod_f == MOD_DISP32)
                            skip_next = 3'd4;
                        else if (mod_f == MOD_NODISP && rm_f == RM_RIP)
                            skip_next = 3'd4;
                        else
                            skip_next = 3'd0;
                        if (rm_f == RM_SIB && mod_f != MOD_REG)
                        begin
                            if (mod_f == MOD_NODISP)
                                skip_next = 3'd0;
                            phase_next = PH_SIB;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    PH_SIB:
                    begin
                        // No-displacement mode with SIB base 5 still carries a disp32.
                        if (modrm_byte_next[7:6] == MOD_NODISP && b[2:0] == RM_RIP)
                            skip_next = 3'd4;
                        adv = 1'b1;
                    end
                    PH_DISP:
                    begin
                        if (skip_next != 3'd0)
                            skip_next = skip_next - 3'd1;
                        if (skip_next == 3'd0)
                            adv = 1'b1;
                    end
                    PH_IMM:
                    begin
                        total = (opcode_next == OP_MOV_IMM32) ? SUM_W'(4) : SUM_W'(1);
                        k = 2'(total - {2'b00, imm_left_next});
                        imm_acc_next = imm_acc_next | ({24'd0, b} << {k, 3'b000});
                        imm_left_next = imm_left_next - 3'd1;
                        if (imm_left_next == 3'd0)
                            done = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (adv)
                begin
                    if (skip_next != 3'd0)
                        phase_next = PH_DISP;
                    else if (imm_left_next != 3'd0)
                        phase_next = PH_IMM;
                    else
                        done = 1'b1;
                end

                // Fail early once the bytes still known to be needed cannot fit.
                if (!fail && !done && phase_next != PH_IDLE)
                begin
                    case (phase_next)
                        PH_PREFIX, PH_OPCODE: need = SUM_W'(2);
                        PH_MODRM: need = SUM_W'(1) + {2'b00, imm_left_next};
                        PH_SIB:   need = SUM_W'(1) + {2'b00, skip_next}
                                         + {2'b00, imm_left_next};
                        PH_DISP:  need = {2'b00, skip_next} + {2'b00, imm_left_next};
                        default:  need = {2'b00, imm_left_next};
                    endcase
                    if ({1'b0, byte_count_next} + need > SUM_W'(MAX_LEN))
                        fail = 1'b1;
                end
            end
        end

        emit            = fail || done;
        out_status_next = ST_FAIL;
        out_src_next    = '0;
        out_imm_next    = '0;
        out_len_next    = '0;
        if (fail)
        begin
            phase_next = PH_IDLE;
        end
        else if (done)
        begin
            phase_next   = PH_IDLE;
            out_len_next = byte_count_next;
            if (opcode_next == OP_MOV_RM8 || opcode_next == OP_MOV_RM32)
            begin
                out_status_next = ST_REG;
                out_src_next    = {rex_r_next, modrm_byte_next[5:3]};
            end
            else
            begin
                out_status_next = ST_IMM;
                out_imm_next    = imm_acc_next;
            end
        end

        if (accept && emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_count_reg   <= '0;
            prefix_count_reg <= '0;
            rex_r_reg        <= 1'b0;
            opcode_reg       <= '0;
            modrm_byte_reg   <= '0;
            skip_reg         <= '0;
            imm_left_reg     <= '0;
            imm_acc_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                prefix_count_reg <= prefix_count_next;
                rex_r_reg        <= rex_r_next;
                opcode_reg       <= opcode_next;
                modrm_byte_reg   <= modrm_byte_next;
                skip_reg         <= skip_next;
                imm_left_reg     <= imm_left_next;
                imm_acc_reg      <= imm_acc_next;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_status_reg <= out_status_next;
            out_src_reg    <= out_src_next;
            out_imm_reg    <= out_imm_next;
            out_len_reg    <= out_len_next;
        end
    end

endmodule

### rtl/core/msd_checker.sv
// Port-level checks for the MOV-store source decoder, bound to the top level.
module msd_checker
    import msd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A word waiting at the output must stay until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // With the output register empty the block always takes input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A failed decode reports no register, immediate or length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FAIL |-> m_tdata == 40'd0)
        else $error("failed decode carries nonzero fields");

    // A register-source result has no immediate and at least opcode and ModRM.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_REG |->
            m_tdata[35:4] == 32'd0 && m_tdata[39:36] >= 4'd2
            && m_tdata[39:36] <= 4'(MAX_LEN))
        else $error("bad register-source result");

    // An immediate result names no register and covers opcode, ModRM and imm.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_IMM |->
            m_tdata[3:0] == 4'd0 && m_tdata[39:36] >= 4'd3
            && m_tdata[39:36] <= 4'(MAX_LEN))
        else $error("bad immediate-source result");

endmodule

bind mov_store_source_decoder msd_checker u_msd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/mov_store_source_decoder_tb.sv
// Self-checking testbench for the MOV-store source decoder.
`timescale 1ns / 1ps

module mov_store_source_decoder_tb
    import msd_pkg::*;
();

    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 120;
    localparam int HOLD_AFTER   = 300;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [3:0] REX_NIBBLE = 4'h4;
    localparam logic [7:0] OP_NOP     = 8'h90;
    localparam logic [7:0] LEGACY_PREFIXES [11] = '{
        8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67
    };

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  src_reg;
        logic [31:0] imm;
        logic [3:0]  len;
    } decode_t;

    // Tracks the parser byte by byte and keeps the decodes still owed by the block.
    class mov_decode_tracker;
        phase_t      ph;
        logic [3:0]  nbytes;
        logic [2:0]  npref;
        logic        rex_r;
        logic [7:0]  opc;
        logic [7:0]  modrm;
        logic [2:0]  skip;
        logic [2:0]  imm_left;
        logic [31:0] imm_acc;
        decode_t     pending_decodes[$];
        int          mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            ph       = PH_IDLE;
            nbytes   = '0;
            npref    = '0;
            rex_r    = 1'b0;
            opc      = '0;
            modrm    = '0;
            skip     = '0;
            imm_left = '0;
            imm_acc  = '0;
        endfunction

        function void emit(logic [1:0] st, logic [3:0] r, logic [31:0] v, logic [3:0] n);
            decode_t d;
            d.status  = st;
            d.src_reg = r;
            d.imm     = v;
            d.len     = n;
            pending_decodes.push_back(d);
            ph = PH_IDLE;
        endfunction

        function void fail();
            emit(ST_FAIL, 4'd0, 32'd0, 4'd0);
        endfunction

        function void finish_insn();
            if (opc == OP_MOV_RM8 || opc == OP_MOV_RM32)
                emit(ST_REG, {rex_r, modrm[5:3]}, 32'd0, nbytes);
            else
                emit(ST_IMM, 4'd0, imm_acc, nbytes);
        endfunction

        function void leave_addr();
            if (skip != 0)
                ph = PH_DISP;
            else if (imm_left != 0)
                ph = PH_IMM;
            else
                finish_insn();
        endfunction

        function void take_opcode(logic [7:0] b);
            opc = b;
            ph  = PH_MODRM;
            if (b == OP_MOV_RM8 || b == OP_MOV_RM32)
                imm_left = 3'd0;
            else if (b == OP_MOV_IMM32)
                imm_left = 3'd4;
            else if (b == OP_MOV_IMM8)
                imm_left = 3'd1;
            else
                fail();
        endfunction

        // Returns 1 when the byte was part of an open instruction.
        function bit take_byte(logic [7:0] b, logic first);
            bit         is_prefix;
            logic [1:0] md;
            logic [2:0] rm;
            int         k;
            int         need;
            if (first)
            begin
                clear();
                ph = PH_PREFIX;
            end
            if (ph == PH_IDLE)
                return 0;
            if (nbytes >= MAX_LEN)
            begin
                fail();
                return 1;
            end
            nbytes = nbytes + 4'd1;
            case (ph)
                PH_PREFIX:
                begin
                    is_prefix = 0;
                    foreach (LEGACY_PREFIXES[i])
                        if (LEGACY_PREFIXES[i] == b)
                            is_prefix = 1;
                    if (npref < 4 && is_prefix)
                        npref = npref + 3'd1;
                    else if (b[7:4] == REX_NIBBLE)
                    begin
                        rex_r = b[2];
                        ph    = PH_OPCODE;
                    end
                    else
                        take_opcode(b);
                end
                PH_OPCODE: take_opcode(b);
                PH_MODRM:
                begin
                    md    = b[7:6];
                    rm    = b[2:0];
                    modrm = b;
                    if (md == MOD_DISP8)
                        skip = 3'd1;
                    else if (md == MOD_DISP32 || (md == MOD_NODISP && rm == RM_RIP))
                        skip = 3'd4;
                    else
                        skip = 3'd0;
                    if (rm == RM_SIB && md != MOD_REG)
                    begin
                        if (md == MOD_NODISP)
                            skip = 3'd0;
                        ph = PH_SIB;
                    end
                    else
                        leave_addr();
                end
                PH_SIB:
                begin
                    // A SIB base of 5 without a ModRM displacement still carries disp32.
                    if (modrm[7:6] == MOD_NODISP && b[2:0] == RM_RIP)
                        skip = 3'd4;
                    leave_addr();
                end
                PH_DISP:
                begin
                    if (skip != 0)
                        skip = skip - 3'd1;
                    if (skip == 0)
                        leave_addr();
                end
                PH_IMM:
                begin
                    k = ((opc == OP_MOV_IMM32) ? 4 : 1) - int'(imm_left);
                    imm_acc  = imm_acc | (32'(b) << (8 * (k & 3)));
                    imm_left = imm_left - 3'd1;
                    if (imm_left == 0)
                        finish_insn();
                end
                default:
                begin
                    ph = PH_IDLE;
                    return 1;
                end
            endcase
            if (ph == PH_IDLE)
                return 1;
            case (ph)
                PH_PREFIX, PH_OPCODE: need = 2;
                PH_MODRM:             need = 1 + int'(imm_left);
                PH_SIB:               need = 1 + int'(skip) + int'(imm_left);
                PH_DISP:              need = int'(skip) + int'(imm_left);
                default:              need = int'(imm_left);
            endcase
            if (int'(nbytes) + need > MAX_LEN)
                fail();
            return 1;
        endfunction

        function void check_decode(decode_t got);
            decode_t want;
            if (pending_decodes.size() == 0)
            begin
                $error("unexpected decode word: status %0d len %0d", got.status, got.len);
                mismatches++;
                return;
            end
            want = pending_decodes.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.src_reg !== want.src_reg)
            begin
                $error("source_reg: expected %0d, got %0d", want.src_reg, got.src_reg);
                mismatches++;
            end
            if (got.imm !== want.imm)
            begin
                $error("imm_value: expected 0x%08h, got 0x%08h", want.imm, got.imm);
                mismatches++;
            end
            if (got.len !== want.len)
            begin
                $error("insn_length: expected %0d, got %0d", want.len, got.len);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    mov_decode_tracker tracker = new();
    logic [7:0] insn_bytes[$];
    int         fed = 0;
    int         cycles = 0;
    bit         quiet = 0;
    bit         hold_request = 0;
    bit         hold_issued = 0;

    // Directed instructions, each entry is {first_byte, insn_byte}.
    localparam logic [8:0] DIRECTED [24] = '{
        {1'b0, 8'h12},                                      // ignored while idle
        {1'b1, 8'h4C}, {1'b0, OP_MOV_RM32}, {1'b0, 8'hF8},  // REX.R, register form
        {1'b1, OP_MOV_RM8},                                 // abandoned by the restart below
        {1'b1, OP_MOV_IMM8}, {1'b0, 8'h00}, {1'b0, 8'hFF},
        {1'b1, OP_NOP},                                     // unknown opcode
        {1'b1, 8'h66}, {1'b0, 8'h66}, {1'b0, 8'h66}, {1'b0, 8'h66}, {1'b0, 8'h66},
        {1'b1, 8'h48}, {1'b0, 8'h66},                       // prefix after REX
        {1'b1, 8'h66}, {1'b0, 8'hF2}, {1'b0, 8'hF3}, {1'b0, 8'h2E},
        {1'b0, 8'h4C}, {1'b0, OP_MOV_IMM32}, {1'b0, 8'h84}, {1'b0, 8'h24}  // too long
    };

    mov_store_source_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("mov_store_source_decoder regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_decode({m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[39:36]});
    end

    // Output side: short random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        if (tracker.take_byte(b, first))
            fed++;
    endtask

    task automatic send_insn(input int count);
        for (int i = 0; i < count; i++)
            push_byte(insn_bytes[i], i == 0);
    endtask

    // Builds a random instruction into insn_bytes; some carry five prefixes, a second REX or a random opcode.
    task automatic build_insn();
        int         npref;
        int         ndisp;
        int         nimm;
        logic [7:0] opc;
        logic [7:0] mrm;
        logic [7:0] sib;
        insn_bytes.delete();
        npref = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(0, 4);
        repeat (npref) insn_bytes.push_back(LEGACY_PREFIXES[$urandom_range(0, 10)]);
        if ($urandom_range(0, 1))
            insn_bytes.push_back({REX_NIBBLE, 4'($urandom_range(0, 15))});
        if ($urandom_range(0, 24) == 0)
            insn_bytes.push_back({REX_NIBBLE, 4'($urandom_range(0, 15))});
        case ($urandom_range(0, 9))
            0:       opc = 8'($urandom);
            1, 2:    opc = OP_MOV_RM8;
            3, 4:    opc = OP_MOV_RM32;
            5, 6:    opc = OP_MOV_IMM8;
            default: opc = OP_MOV_IMM32;
        endcase
        insn_bytes.push_back(opc);
        mrm = 8'($urandom);
        insn_bytes.push_back(mrm);
        if (mrm[7:6] == MOD_DISP8)
            ndisp = 1;
        else if (mrm[7:6] == MOD_DISP32 || (mrm[7:6] == MOD_NODISP && mrm[2:0] == RM_RIP))
            ndisp = 4;
        else
            ndisp = 0;
        if (mrm[7:6] != MOD_REG && mrm[2:0] == RM_SIB)
        begin
            sib = 8'($urandom);
            insn_bytes.push_back(sib);
            if (mrm[7:6] == MOD_NODISP)
                ndisp = (sib[2:0] == RM_RIP) ? 4 : 0;
        end
        repeat (ndisp) insn_bytes.push_back(8'($urandom));
        nimm = (opc == OP_MOV_IMM32) ? 4 : (opc == OP_MOV_IMM8) ? 1 : 0;
        repeat (nimm) insn_bytes.push_back(8'($urandom));
    endtask

    initial
    begin
        int pick;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            push_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        fed = 0;
        while (fed < RANDOM_ITEMS)
        begin
            quiet = (fed >= RANDOM_ITEMS - QUIET_ITEMS);
            if (fed >= HOLD_AFTER && !hold_issued)
            begin
                hold_issued  = 1;
                hold_request = 1;
            end
            pick = $urandom_range(0, 99);
            build_insn();
            if (pick < 78)
                send_insn(insn_bytes.size());
            else if (pick < 88)
                send_insn($urandom_range(1, insn_bytes.size()));
            else if (pick < 94)
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'($urandom));
            else
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("mov_store_source_decoder regression: pass");
        else
            $display("mov_store_source_decoder regression: fail");
        $finish;
    end

endmodule

### files.f
rtl/core/msd_pkg.sv
rtl/core/mov_store_source_decoder.sv
rtl/core/msd_checker.sv
tb/mov_store_source_decoder_tb.sv
